[rtl/mlm_pkg.sv]
// Types and constants shared by the mutex lock manager files.
package mlm_pkg;

    localparam int OP_W  = 2;
    localparam int MID_W = 5;
    localparam int TID_W = 4;
    localparam int ST_W  = 3;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 2'd0,
        OP_LOCK   = 2'd1,
        OP_UNLOCK = 2'd2
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK         = 3'd0,
        ST_QUEUED     = 3'd1,
        ST_UNKNOWN    = 3'd2,
        ST_NOT_LOCKED = 3'd3,
        ST_NOT_OWNER  = 3'd4,
        ST_FULL       = 3'd5,
        ST_WAITING    = 3'd6
    } status_t;

endpackage

[rtl/mlm_ifs.sv]
// Request and response channel interfaces of the mutex lock manager.
interface mlm_req_if;
    logic                       valid;
    logic                       ready;
    logic [mlm_pkg::OP_W-1:0]   operation;
    logic [mlm_pkg::MID_W-1:0]  mutex_id;
    logic [mlm_pkg::TID_W-1:0]  thread_id;

    modport source (output valid, output operation, output mutex_id, output thread_id,
                    input ready);
    modport sink   (input valid, input operation, input mutex_id, input thread_id,
                    output ready);
endinterface

interface mlm_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [mlm_pkg::ST_W-1:0]   status;
    logic [mlm_pkg::MID_W-1:0]  new_mutex;
    logic                       wake_valid;
    logic [mlm_pkg::TID_W-1:0]  wake_thread;

    modport source (output valid, output status, output new_mutex, output wake_valid,
                    output wake_thread, input ready);
    modport sink   (input valid, input status, input new_mutex, input wake_valid,
                    input wake_thread, output ready);
endinterface

[rtl/mutex_lock_manager.sv]
// Mutex table with per-mutex FIFO waiter queues.
// A request goes through the input reg, then the result reg; the table update is a
// single read-modify-write. Throughput: one request per cycle while rsp.ready is high.
// Next request sees all state changes of the previous one.
// Reset (async, rst_n low): no mutexes exist, none held, no waiters, no thread blocked.
// Owner, queue head/tail and link tables are undefined until written.
module mutex_lock_manager #(
    parameter int NUM_MUTEXES = 16,
    parameter int NUM_THREADS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    mlm_req_if.sink    req,
    mlm_rsp_if.source  rsp
);
    import mlm_pkg::*;

    // Only ids that fit the request fields can ever be addressed.
    localparam int MUTEX_SLOTS = (NUM_MUTEXES < 31) ? NUM_MUTEXES : 31;
    localparam int THREAD_SLOTS = (NUM_THREADS < 16) ? NUM_THREADS : 16;
    localparam int MIW = $clog2(MUTEX_SLOTS);
    localparam int TIW = $clog2(THREAD_SLOTS);
    localparam int CW  = $clog2(NUM_MUTEXES + 2);

    // input stage
    logic              req_v_reg;
    logic [OP_W-1:0]   op_reg;
    logic [MID_W-1:0]  mid_reg;
    logic [TID_W-1:0]  tid_reg;

    // result stage
    logic              rsp_v_reg;
    status_t           status_reg;
    logic [MID_W-1:0]  new_mutex_reg;
    logic              wake_valid_reg;
    logic [TID_W-1:0]  wake_thread_reg;

    // table state
    logic [CW-1:0]           next_num_reg, next_num_next;
    logic [MUTEX_SLOTS-1:0]  held_reg, held_next;
    logic [MUTEX_SLOTS-1:0]  nonempty_reg, nonempty_next;
    logic [THREAD_SLOTS-1:0] blocked_reg, blocked_next;
    logic [TID_W-1:0]        owner_reg [MUTEX_SLOTS];
    logic [TID_W-1:0]        owner_next [MUTEX_SLOTS];
    logic [TID_W-1:0]        head_reg [MUTEX_SLOTS];
    logic [TID_W-1:0]        head_next [MUTEX_SLOTS];
    logic [TID_W-1:0]        tail_reg [MUTEX_SLOTS];
    logic [TID_W-1:0]        tail_next [MUTEX_SLOTS];
    logic [TID_W-1:0]        link_reg [THREAD_SLOTS];
    logic [TID_W-1:0]        link_next [THREAD_SLOTS];

    logic              adv;
    status_t           status_next;
    logic [MID_W-1:0]  new_mutex_next;
    logic              wake_valid_next;
    logic [TID_W-1:0]  wake_thread_next;

    logic              mid_known;
    logic [MIW-1:0]    m;
    logic              tid_ok;
    logic [TIW-1:0]    tix;
    logic [TID_W-1:0]  w;
    logic              w_ok;
    logic [TID_W-1:0]  t;
    logic              t_ok;

    assign adv       = req_v_reg && (!rsp_v_reg || rsp.ready);
    assign req.ready = !req_v_reg || adv;

    assign rsp.valid       = rsp_v_reg;
    assign rsp.status      = status_reg;
    assign rsp.new_mutex   = new_mutex_reg;
    assign rsp.wake_valid  = wake_valid_reg;
    assign rsp.wake_thread = wake_thread_reg;

    assign mid_known = (mid_reg != '0) && (32'(mid_reg) < 32'(next_num_reg))
                       && (32'(mid_reg) <= NUM_MUTEXES);
    assign m      = MIW'(mid_reg - MID_W'(1));
    assign tid_ok = 32'(tid_reg) < THREAD_SLOTS;
    assign tix    = TIW'(tid_reg);
    assign w      = head_reg[m];
    assign w_ok   = 32'(w) < THREAD_SLOTS;
    assign t      = tail_reg[m];
    assign t_ok   = 32'(t) < THREAD_SLOTS;

    always_comb
    begin
        next_num_next    = next_num_reg;
        held_next        = held_reg;
        nonempty_next    = nonempty_reg;
        blocked_next     = blocked_reg;
        owner_next       = owner_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        link_next        = link_reg;
        status_next      = ST_OK;
        new_mutex_next   = '0;
        wake_valid_next  = 1'b0;
        wake_thread_next = '0;

        case (op_t'(op_reg))
            OP_CREATE:
            begin
                if (32'(next_num_reg) > NUM_MUTEXES)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    new_mutex_next = MID_W'(next_num_reg);
                    next_num_next  = next_num_reg + CW'(1);
                end
            end
            OP_LOCK:
            begin
                if (!mid_known)
                begin
                    status_next = ST_UNKNOWN;
                end
                else if (tid_ok && blocked_reg[tix])
                begin
                    status_next = ST_WAITING;
                end
                else if (!held_reg[m])
                begin
                    held_next[m]  = 1'b1;
                    owner_next[m] = tid_reg;
                end
                else if (!tid_ok)
                begin
                    status_next = ST_WAITING;
                end
                else
                begin
                    if (!nonempty_reg[m])
                    begin
                        nonempty_next[m] = 1'b1;
                        head_next[m]     = tid_reg;
                    end
                    else if (t_ok)
                    begin
                        link_next[TIW'(t)] = tid_reg;
                    end
                    tail_next[m]      = tid_reg;
                    blocked_next[tix] = 1'b1;
                    status_next       = ST_QUEUED;
                end
            end
            OP_UNLOCK:
            begin
                if (!mid_known)
                begin
                    status_next = ST_UNKNOWN;
                end
                else if (!held_reg[m])
                begin
                    status_next = ST_NOT_LOCKED;
                end
                else if (owner_reg[m] != tid_reg)
                begin
                    status_next = ST_NOT_OWNER;
                end
                else if (!nonempty_reg[m])
                begin
                    held_next[m] = 1'b0;
                end
                else
                begin
                    if (w == t)
                    begin
                        nonempty_next[m] = 1'b0;
                    end
                    else if (w_ok)
                    begin
                        head_next[m] = link_reg[TIW'(w)];
                    end
                    if (w_ok)
                    begin
                        blocked_next[TIW'(w)] = 1'b0;
                    end
                    owner_next[m]    = w;
                    wake_valid_next  = 1'b1;
                    wake_thread_next = w;
                end
            end
            default:
            begin
                status_next = ST_UNKNOWN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_v_reg    <= 1'b0;
            rsp_v_reg    <= 1'b0;
            next_num_reg <= CW'(1);
            held_reg     <= '0;
            nonempty_reg <= '0;
            blocked_reg  <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                req_v_reg <= req.valid;
            end
            if (adv)
            begin
                rsp_v_reg    <= 1'b1;
                next_num_reg <= next_num_next;
                held_reg     <= held_next;
                nonempty_reg <= nonempty_next;
                blocked_reg  <= blocked_next;
            end
            else if (rsp.ready)
            begin
                rsp_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg  <= req.operation;
            mid_reg <= req.mutex_id;
            tid_reg <= req.thread_id;
        end
        if (adv)
        begin
            status_reg      <= status_next;
            new_mutex_reg   <= new_mutex_next;
            wake_valid_reg  <= wake_valid_next;
            wake_thread_reg <= wake_thread_next;
            owner_reg       <= owner_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            link_reg        <= link_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_wake_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_v_reg && wake_valid_reg |-> status_reg == ST_OK)
        else $error("wake reported without ok status");

    a_num_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(next_num_reg) <= NUM_MUTEXES + 1 && next_num_reg != '0)
        else $error("mutex counter out of range");

    a_queue_held: assert property (@(posedge clk) disable iff (!rst_n)
        (nonempty_reg & ~held_reg) == '0)
        else $error("waiters on a free mutex");

    a_blocked_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (blocked_reg != '0) |-> (nonempty_reg != '0))
        else $error("blocked thread with no waiter queue");
`endif

endmodule
